// ===== hw/rtl/shelf_atlas_packer_defines.svh =====
// Assertion helpers for the shelf atlas packer.
// Each macro expects clk and arst_n in scope.
`ifndef SHELF_ATLAS_PACKER_DEFINES_SVH
`define SHELF_ATLAS_PACKER_DEFINES_SVH

// Property checked on every rising edge outside reset
`define SAP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define SAP_ASSERT_NEVER(lbl, cond, msg) \
	`SAP_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/sap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sap_pkg;

	// Atlas geometry; sides are powers of two
	localparam int INIT_SIDE = 512;
	localparam int MAX_SIDE  = 4096;
	localparam int INIT_LOG  = $clog2(INIT_SIDE);
	localparam int MAX_LOG   = $clog2(MAX_SIDE);

	// Field widths
	localparam int SIDE_W = 13;
	localparam int EXP_W  = 4;
	localparam int DIM_W  = 8;
	localparam int PAD_W  = 4;
	localparam int PDIM_W = 9;
	localparam int DEST_W = 12;
	localparam int UV_W   = 17;
	localparam int UV_FRAC = 16;

	// Cursor and edge sums, one bit over the side
	localparam int CW = SIDE_W + 1;

	// Status codes
	localparam logic STATUS_PLACED = 1'b0;
	localparam logic STATUS_FULL   = 1'b1;

	// Request held in the input stage
	typedef struct packed {
		logic             vld;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} sap_req_t;

	// One result beat
	typedef struct packed {
		logic              status;
		logic [DEST_W-1:0] dest_x;
		logic [DEST_W-1:0] dest_y;
		logic [SIDE_W-1:0] atlas_side;
		logic              grew;
		logic [UV_W-1:0]   uv_min_x;
		logic [UV_W-1:0]   uv_min_y;
		logic [UV_W-1:0]   uv_max_x;
		logic [UV_W-1:0]   uv_max_y;
	} sap_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sap_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sap_in_reg
	import sap_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [DIM_W-1:0] rect_width,
	input  wire logic [DIM_W-1:0] rect_height,
	input  wire logic             adv,
	output sap_req_t              req_s1
);

	logic             vld_s1;
	logic [DIM_W-1:0] w_s1;
	logic [DIM_W-1:0] h_s1;

	// hold while the held request cannot move on
	assign in_stall = vld_s1 && !adv;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	// payload, loaded on an accepted beat
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			w_s1 <= rect_width;
			h_s1 <= rect_height;
		end
	end

	assign req_s1 = '{vld: vld_s1, w: w_s1, h: h_s1};

endmodule

`default_nettype wire

// ===== hw/rtl/sap_place.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "shelf_atlas_packer_defines.svh"

module sap_place
	import sap_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [PAD_W-1:0] pad,
	input  wire sap_req_t         req_s1,
	input  wire logic             fire,
	output sap_result_t           res
);

	// packer state
	logic [SIDE_W-1:0] cx_q, cy_q;
	logic [PDIM_W-1:0] rt_q;
	logic [EXP_W-1:0]  exp_q;

	logic [SIDE_W-1:0] cx_d, cy_d;
	logic [PDIM_W-1:0] rt_d;
	logic [EXP_W-1:0]  exp_d;

	logic [SIDE_W-1:0] side, side_d;
	logic [PDIM_W-1:0] pw, ph;
	logic              zero_sz, wrap, fit1, found, placed;
	logic [SIDE_W-1:0] cx1, cy1, px, py;
	logic [PDIM_W-1:0] rt1;
	logic [EXP_W-1:0]  gexp;
	logic [CW-1:0]     dx, dy, ex, ey;
	logic [EXP_W:0]    uv_sh;
	logic              full_now;

	// edge * 2^16 / side, side a power of two
	function automatic logic [UV_W-1:0] to_uv(input logic [CW-1:0] edge_v,
		input logic [EXP_W:0] sh);
		logic [CW+UV_FRAC-1:0] wide;
		wide = (CW+UV_FRAC)'(edge_v) << sh;
		return wide[UV_W-1:0];
	endfunction

	assign side    = SIDE_W'(1) << exp_q;
	assign pw      = PDIM_W'(req_s1.w) + PDIM_W'({pad, 1'b0});
	assign ph      = PDIM_W'(req_s1.h) + PDIM_W'({pad, 1'b0});
	assign zero_sz = (req_s1.w == '0) || (req_s1.h == '0);

	// first try at the current side, with a row wrap if needed
	always_comb begin
		logic [CW-1:0] cy_wr;
		cy_wr = CW'(cy_q) + CW'(rt_q) + CW'(pad);
		wrap  = (CW'(cx_q) + CW'(pw)) > CW'(side);
		cx1   = wrap ? '0 : cx_q;
		cy1   = wrap ? cy_wr[SIDE_W-1:0] : cy_q;
		rt1   = wrap ? '0 : rt_q;
		fit1  = (CW'(pw) <= CW'(side)) && ((CW'(cy1) + CW'(ph)) <= CW'(side));
	end

	// smallest larger side that holds the padded rectangle
	always_comb begin
		found = 1'b0;
		gexp  = EXP_W'(MAX_LOG);
		for (int e = MAX_LOG; e > INIT_LOG; e--) begin
			if ((e > int'(exp_q)) && (CW'(pw) <= (CW'(1) << e))
				&& (CW'(ph) <= (CW'(1) << e))) begin
				found = 1'b1;
				gexp  = EXP_W'(e);
			end
		end
	end

	// placement decision and next state
	always_comb begin
		logic [CW-1:0] cx_sum;
		cx_sum = '0;
		cx_d   = cx_q;
		cy_d   = cy_q;
		rt_d   = rt_q;
		exp_d  = exp_q;
		placed = 1'b0;
		px     = '0;
		py     = '0;
		res    = '0;
		res.status = STATUS_PLACED;
		if (zero_sz) begin
			res.atlas_side = side;
		end else if (fit1) begin
			placed = 1'b1;
			px     = cx1;
			py     = cy1;
			cx_sum = CW'(cx1) + CW'(pw);
			cx_d   = cx_sum[SIDE_W-1:0];
			cy_d   = cy1;
			rt_d   = (ph > rt1) ? ph : rt1;
		end else if (int'(exp_q) < MAX_LOG) begin
			res.grew = 1'b1;
			if (found) begin
				placed = 1'b1;
				exp_d  = gexp;
				cx_d   = SIDE_W'(pw);
				cy_d   = '0;
				rt_d   = ph;
			end else begin
				// every larger side failed; the last wrap at the top side stays
				res.status = STATUS_FULL;
				exp_d = EXP_W'(MAX_LOG);
				cx_d  = '0;
				cy_d  = (CW'(pw) > CW'(MAX_SIDE)) ? SIDE_W'(pad) : '0;
				rt_d  = '0;
			end
		end else begin
			res.status = STATUS_FULL;
			cx_d = cx1;
			cy_d = cy1;
			rt_d = rt1;
		end
		side_d = SIDE_W'(1) << exp_d;
		if (!zero_sz) begin
			res.atlas_side = side_d;
		end
		// corner and UVs
		dx    = CW'(px) + CW'(pad);
		dy    = CW'(py) + CW'(pad);
		ex    = dx + CW'(req_s1.w);
		ey    = dy + CW'(req_s1.h);
		uv_sh = (EXP_W+1)'(UV_FRAC) - (EXP_W+1)'(exp_d);
		if (placed) begin
			res.dest_x   = dx[DEST_W-1:0];
			res.dest_y   = dy[DEST_W-1:0];
			res.uv_min_x = to_uv(dx, uv_sh);
			res.uv_min_y = to_uv(dy, uv_sh);
			res.uv_max_x = to_uv(ex, uv_sh);
			res.uv_max_y = to_uv(ey, uv_sh);
		end
	end

	assign full_now = (res.status == STATUS_FULL);

	// state update when the request moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			rt_q  <= '0;
			exp_q <= EXP_W'(INIT_LOG);
		end else if (fire) begin
			cx_q  <= cx_d;
			cy_q  <= cy_d;
			rt_q  <= rt_d;
			exp_q <= exp_d;
		end
	end

	`SAP_ASSERT(a_side_range, (int'(exp_q) >= INIT_LOG) && (int'(exp_q) <= MAX_LOG), "bad side")
	`SAP_ASSERT(a_cursor_in_row, CW'(cx_q) <= CW'(side), "cursor past the atlas edge")
	`SAP_ASSERT(a_grew_moves_side, fire && res.grew |=> exp_q != $past(exp_q), "no growth")
	`SAP_ASSERT(a_full_at_max, fire && full_now |=> int'(exp_q) == MAX_LOG, "full below max side")
	`SAP_ASSERT_NEVER(a_zero_kept, fire && zero_sz && (res.grew || full_now), "empty moved state")

endmodule

`default_nettype wire

// ===== hw/rtl/shelf_atlas_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shelf packer for a square texture atlas.
// A request beat is held in the input register, then moves to the result register.
// Throughput: one request per cycle unless stalled; each placement is decided in the
// single compare/add pass between the input register and the result register.
// Reset (arst_n low, asynchronous): cursor and row at zero, side 512, pad 1,
// both pipeline stages empty.

module shelf_atlas_packer
	import sap_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// config write
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [PAD_W-1:0]  cfg_data,
	// requests
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [DIM_W-1:0]  rect_width,
	input  wire logic [DIM_W-1:0]  rect_height,
	// results
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   status,
	output logic [DEST_W-1:0]      dest_x,
	output logic [DEST_W-1:0]      dest_y,
	output logic [SIDE_W-1:0]      atlas_side,
	output logic                   grew,
	output logic [UV_W-1:0]        uv_min_x,
	output logic [UV_W-1:0]        uv_min_y,
	output logic [UV_W-1:0]        uv_max_x,
	output logic [UV_W-1:0]        uv_max_y
);

	logic [PAD_W-1:0] pad_q;
	sap_req_t         req_s1;
	sap_result_t      res;
	sap_result_t      res_s2;
	logic             vld_s2;
	logic             adv, fire;

	// padding register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= PAD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			pad_q <= cfg_data;
		end
	end

	// result register frees up when empty or taken
	assign adv  = !vld_s2 || !out_stall;
	assign fire = req_s1.vld && adv;

	sap_in_reg u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.adv         (adv),
		.req_s1      (req_s1)
	);

	sap_place u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.pad    (pad_q),
		.req_s1 (req_s1),
		.fire   (fire),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= req_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = vld_s2;
	assign status     = res_s2.status;
	assign dest_x     = res_s2.dest_x;
	assign dest_y     = res_s2.dest_y;
	assign atlas_side = res_s2.atlas_side;
	assign grew       = res_s2.grew;
	assign uv_min_x   = res_s2.uv_min_x;
	assign uv_min_y   = res_s2.uv_min_y;
	assign uv_max_x   = res_s2.uv_max_x;
	assign uv_max_y   = res_s2.uv_max_y;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import sap_pkg::*;

	localparam int LIMIT = 300000;

	// Expected beat right after reset for a zero-sized request
	localparam sap_result_t EMPTY_512 = {STATUS_PLACED, 12'd0, 12'd0, 13'd512, 1'b0,
		17'd0, 17'd0, 17'd0, 17'd0};

	typedef enum {SZ_SMALL, SZ_ANY, SZ_BIG} size_mix_t;

	// One directed request; want is used only when typed is set
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic             typed;
		sap_result_t      want;
	} rect_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PAD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [DIM_W-1:0] rect_width = '0;
	logic [DIM_W-1:0] rect_height = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [DEST_W-1:0] dest_x;
	logic [DEST_W-1:0] dest_y;
	logic [SIDE_W-1:0] atlas_side;
	logic grew;
	logic [UV_W-1:0] uv_min_x;
	logic [UV_W-1:0] uv_min_y;
	logic [UV_W-1:0] uv_max_x;
	logic [UV_W-1:0] uv_max_y;

	// Shadow of the packer state
	int pad_now = 1;
	int cur_x = 0;
	int cur_y = 0;
	int row_h = 0;
	int side_now = INIT_SIDE;
	int refusals = 0;

	sap_result_t placements[$];
	rect_row_t plan[$];
	sap_result_t oldest;
	int fails = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	int stall_left = 0;

	shelf_atlas_packer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.atlas_side (atlas_side),
		.grew       (grew),
		.uv_min_x   (uv_min_x),
		.uv_min_y   (uv_min_y),
		.uv_max_x   (uv_max_x),
		.uv_max_y   (uv_max_y)
	);

	always #5 clk = ~clk;

	// Append one row to the directed table
	function automatic void add_plan(input rect_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	// Queue one expected result beat
	function automatic void expect_beat(input sap_result_t r);
		placements.insert(placements.size(), r);
	endfunction

	// Pixel position over side in 1.16 fixed point, truncated
	function automatic logic [UV_W-1:0] uv_of(input int px, input int side);
		longint scaled;
		scaled = longint'(px) << UV_FRAC;
		return UV_W'(scaled / side);
	endfunction

	// Shelf placement of one request; updates the shadow state
	function automatic sap_result_t place_rect(input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		sap_result_t r;
		int pw, ph, dx, dy;
		bit placed, refused, grown;
		r = '0;
		placed = 1'b0;
		refused = 1'b0;
		grown = 1'b0;
		if (w == 0 || h == 0) begin
			r.atlas_side = SIDE_W'(side_now);
		end else begin
			pw = w + 2 * pad_now;
			ph = h + 2 * pad_now;
			while (!placed && !refused) begin
				// wrap to the next row
				if (cur_x + pw > side_now) begin
					cur_x = 0;
					cur_y = (cur_y + row_h + pad_now) & 'h1FFF;
					row_h = 0;
				end
				if (pw <= side_now && cur_y + ph <= side_now) begin
					placed = 1'b1;
				end else if (side_now < MAX_SIDE) begin
					side_now = (side_now * 2 > MAX_SIDE) ? MAX_SIDE : side_now * 2;
					cur_x = 0;
					cur_y = 0;
					row_h = 0;
					grown = 1'b1;
				end else begin
					refused = 1'b1;
				end
			end
			r.atlas_side = SIDE_W'(side_now);
			r.grew = grown;
			if (refused) begin
				r.status = STATUS_FULL;
				refusals++;
			end else begin
				dx = cur_x + pad_now;
				dy = cur_y + pad_now;
				r.status = STATUS_PLACED;
				r.dest_x = DEST_W'(dx);
				r.dest_y = DEST_W'(dy);
				r.uv_min_x = uv_of(dx, side_now);
				r.uv_min_y = uv_of(dy, side_now);
				r.uv_max_x = uv_of(dx + w, side_now);
				r.uv_max_y = uv_of(dy + h, side_now);
				cur_x = (cur_x + pw) & 'h1FFF;
				if (ph > row_h)
					row_h = ph & 'h1FF;
			end
		end
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim(input size_mix_t mix);
		case (mix)
			SZ_SMALL: begin
				if ($urandom_range(0, 31) == 0)
					return '0;
				return DIM_W'($urandom_range(1, 40));
			end
			SZ_BIG: return DIM_W'($urandom_range(180, 255));
			default: return DIM_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Present one request and wait until the packer accepts it
	task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input bit typed, input sap_result_t want);
		sap_result_t got;
		in_valid <= 1'b1;
		rect_width <= w;
		rect_height <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = place_rect(w, h);
		expect_beat(typed ? want : got);
	endtask

	task automatic maybe_gap();
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
	endtask

	// Stop sending and let the pipe empty out
	task automatic settle();
		in_valid <= 1'b0;
		while (placements.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_pad(input int pad);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= PAD_W'(pad);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		pad_now = pad;
	endtask

	task automatic run_phase(input int count, input size_mix_t mix, input bit idling,
			input int min_full);
		int n;
		idle_on = idling;
		n = 0;
		while (n < count || (refusals < min_full && n < 700)) begin
			maybe_gap();
			// occasional full drain mid-phase
			if (idling && $urandom_range(0, 99) == 0)
				settle();
			send_rect(pick_dim(mix), pick_dim(mix), 1'b0, '0);
			n++;
		end
	endtask

	// Receiver stalls in random bursts
	always @(posedge clk) begin
		if (!arst_n || !idle_on) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!out_stall && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			fails++;
		end
	endtask

	// Result beats against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (placements.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				oldest = placements.pop_front();
				check_field("status", int'(oldest.status), int'(status));
				check_field("dest_x", int'(oldest.dest_x), int'(dest_x));
				check_field("dest_y", int'(oldest.dest_y), int'(dest_y));
				check_field("atlas_side", int'(oldest.atlas_side), int'(atlas_side));
				check_field("grew", int'(oldest.grew), int'(grew));
				check_field("uv_min_x", int'(oldest.uv_min_x), int'(uv_min_x));
				check_field("uv_min_y", int'(oldest.uv_min_y), int'(uv_min_y));
				check_field("uv_max_x", int'(oldest.uv_max_x), int'(uv_max_x));
				check_field("uv_max_y", int'(oldest.uv_max_y), int'(uv_max_y));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		// directed requests, pad 1 from reset
		add_plan({8'd10, 8'd20, 1'b1, {STATUS_PLACED, 12'd1, 12'd1, 13'd512, 1'b0,
			17'd128, 17'd128, 17'd1408, 17'd2688}});
		add_plan({8'd0, 8'd0, 1'b1, EMPTY_512});
		add_plan({8'd0, 8'd255, 1'b1, EMPTY_512});
		add_plan({8'd255, 8'd0, 1'b1, EMPTY_512});
		add_plan({8'd255, 8'd255, 1'b0, EMPTY_512});
		add_plan({8'd1, 8'd1, 1'b0, EMPTY_512});
		add_plan({8'd255, 8'd1, 1'b0, EMPTY_512});
		add_plan({8'd1, 8'd255, 1'b0, EMPTY_512});
		add_plan({8'd128, 8'd128, 1'b0, EMPTY_512});
		add_plan({8'd127, 8'd127, 1'b0, EMPTY_512});
		add_plan({8'd170, 8'd85, 1'b0, EMPTY_512});
		add_plan({8'd85, 8'd170, 1'b0, EMPTY_512});
		// fill rows until the atlas has to grow
		repeat (8)
			add_plan({8'd255, 8'd255, 1'b0, EMPTY_512});
		add_plan({8'd0, 8'd7, 1'b0, EMPTY_512});
		add_plan({8'd200, 8'd3, 1'b0, EMPTY_512});

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			maybe_gap();
			send_rect(plan[i].w, plan[i].h, plan[i].typed, plan[i].want);
		end

		write_pad(0);
		run_phase(150, SZ_SMALL, 1'b1, 0);
		write_pad(15);
		run_phase(150, SZ_ANY, 1'b1, 0);
		write_pad($urandom_range(0, 15));
		run_phase(150, SZ_ANY, 1'b0, 0);
		write_pad(7);
		run_phase(150, SZ_SMALL, 1'b1, 0);
		write_pad($urandom_range(0, 15));
		run_phase(150, SZ_ANY, 1'b1, 0);
		// large rectangles until the atlas refuses repeatedly; no idling
		write_pad(15);
		run_phase(280, SZ_BIG, 1'b0, refusals + 40);

		settle();
		repeat (6)
			@(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
